>>> rtl/core/ttt_pkg.sv
//------------------------------------------------------------------------------
// ttt_pkg
// Shared types and constants of the tap and clock tempo tracker.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttt_pkg;

  localparam int RING_DEPTH = 24;
  localparam int RING_HALF  = RING_DEPTH / 2;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int SUM_W      = 20 + $clog2(RING_DEPTH + 1);

  localparam int TEMPO_W = 28;
  localparam int DEN_W   = 23;   // 125 * ratio_q12
  localparam int IVX_W   = 34;   // interval * 3

  localparam logic [TEMPO_W-1:0] TEMPO_MAX   = {TEMPO_W{1'b1}};
  localparam logic [TEMPO_W-1:0] TEMPO_RESET = 28'd128000000;
  localparam logic [15:0]        COEF_FAST   = 16'd32768;
  localparam logic [15:0]        COEF_SLOW   = 16'd721;
  localparam logic [TEMPO_W-1:0] HOLD_BAND   = 28'd1280;
  localparam logic [4:0]         PPQ_LONG    = 5'd24;
  localparam logic [25:0]        CLK_LO_LIM  = 26'd960;
  localparam logic [25:0]        CLK_HI_LIM  = 26'd288000;
  localparam logic [6:0]         DEN_MUL     = 7'd125;

  typedef enum logic [1:0] {
    FN_TAP   = 2'd0,
    FN_CLOCK = 2'd1,
    FN_TICK  = 2'd2,
    FN_SET   = 2'd3
  } ttt_func_t;

  typedef enum logic [2:0] {
    REG_MIN_TAP = 3'd0,
    REG_MAX_TAP = 3'd1,
    REG_TOL     = 3'd2,
    REG_RATIO   = 3'd3,
    REG_PPQ     = 3'd4
  } ttt_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TAP_MUL,
    ST_TAP_DEC,
    ST_TAP_DIV,
    ST_CLK_CHK,
    ST_CLK_SUM,
    ST_CLK_DRAIN,
    ST_CLK_FIN,
    ST_TICK_MUL,
    ST_TICK_ADD,
    ST_TICK_HOLD,
    ST_SET,
    ST_DONE
  } ttt_state_t;

  typedef struct packed {
    logic               start;
    logic [DEN_W-1:0]   rem_init;
    logic [TEMPO_W-1:0] low_init;
    logic [DEN_W-1:0]   den;
  } ttt_div_req_t;

endpackage

>>> rtl/core/ttt_div.sv
//------------------------------------------------------------------------------
// ttt_div
// Restoring divider, one quotient bit per cycle, 28-bit quotient.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttt_div
  import ttt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ttt_div_req_t       req,
  output logic               done,
  output logic [TEMPO_W-1:0] quot
);

  localparam int CNT_W = $clog2(TEMPO_W);

  logic [DEN_W-1:0]   rem_r, rem_nxt;
  logic [TEMPO_W-1:0] low_r, low_nxt;
  logic [DEN_W-1:0]   den_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r, done_r;
  logic [DEN_W:0]     trial;
  logic               qbit;

  always_comb begin
    trial   = {rem_r, low_r[TEMPO_W-1]};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    low_nxt = {low_r[TEMPO_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(TEMPO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      low_r <= req.low_init;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
    end
  end

  assign done = done_r;
  assign quot = low_r;

endmodule

>>> rtl/core/tap_and_clock_tempo_tracker_unit.sv
//------------------------------------------------------------------------------
// tap_and_clock_tempo_tracker_unit
// Delay tempo tracker fed by taps, clock periods, smoothing ticks and loads.
//------------------------------------------------------------------------------
// One item in, one result out, one item at a time. An accepted clock pulse
// reads every ring entry of the current mode from the period memory, one ring
// entry per cycle; a clock pulse outside its window skips the ring. A tap runs
// the serial divider when it yields a new tempo; a saturated tempo skips it.
// The next item is accepted as soon as the result is registered, even while
// that result still waits on out_tready. Ring entries never written read as
// zero through per-entry valid bits cleared at reset; no clearing pass.
`timescale 1ns / 1ps

module tap_and_clock_tempo_tracker_unit
  import ttt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // time_us[31:0], clock_period[51:32], tempo_value[79:52]
  input  logic [1:0]  in_tuser,   // func[1:0]
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // tempo_now[27:0], delay_length[55:28], last_interval_us[87:56]
  output logic [0:0]  out_tuser   // tempo_updated[0]
);

  // configuration
  logic [31:0] min_r, max_r;
  logic [15:0] tol_r, ratio_r;
  logic [4:0]  ppq_r;

  // tracker state
  logic [31:0]        last_tap_r, last_int_r;
  logic               first_r;
  logic [TEMPO_W-1:0] tempo_r, smooth_r, held_r;
  logic [RING_AW-1:0] idx_r;

  // latched item
  logic [31:0]        time_r;
  logic [19:0]        per_r;
  logic [TEMPO_W-1:0] tval_r;

  // working registers
  logic [31:0]        iv_r;
  logic [IVX_W-1:0]   ivx_r;
  logic [47:0]        rhs_r;
  logic [DEN_W-1:0]   den_r;
  logic [SUM_W-1:0]   sum_r;
  logic [RING_AW-1:0] cnt_r;
  logic               rd_v_r;
  logic [43:0]        m_r;
  logic               neg_r;
  logic               upd_r;

  // output register
  logic        out_v_r;
  logic        out_upd_r;
  logic [87:0] out_data_r;

  ttt_state_t state_r, state_nxt;

  // ring memory
  logic [19:0]           ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_vld_r;
  logic [19:0]           rd_data_r;
  logic                  rd_vld_r;
  logic                  mem_we, mem_re, div_start, res_load;

  // combinational helpers
  logic               in_acc, lng;
  logic [31:0]        iv;
  logic               in_rng, tol_fail, sat_tap;
  logic [25:0]        lo_prod, hi_prod;
  logic               clk_ok;
  logic [RING_AW-1:0] idx_new, last_cnt;
  logic [SUM_W-1:0]   clk_val;
  logic               clk_sat, clk_upd;
  logic [TEMPO_W:0]   sm_diff;
  logic [44:0]        m_up;
  logic [TEMPO_W-1:0] hold_diff;
  logic [TEMPO_W-1:0] div_quot;
  logic               div_done;
  ttt_div_req_t       div_req;

  assign in_acc = in_tvalid && in_tready;
  assign lng    = (ppq_r == PPQ_LONG);

  always_comb begin
    iv       = time_r - last_tap_r;
    in_rng   = (min_r <= iv_r) && (iv_r <= max_r);
    tol_fail = !first_r && ({2'b00, iv_r, 14'd0} >= rhs_r);
    // quotient would not fit in 28 bits (also covers a zero ratio)
    sat_tap  = ({4'd0, den_r} <= ivx_r[IVX_W-1:7]);

    // period window [960/ppq, 288000/ppq] without dividing
    lo_prod  = (26'(per_r) + 26'd1) * 26'(ppq_r);
    hi_prod  = 26'(per_r) * 26'(ppq_r);
    clk_ok   = (lo_prod > CLK_LO_LIM) && (hi_prod <= CLK_HI_LIM);

    if (lng) begin
      idx_new  = (idx_r == RING_AW'(RING_DEPTH - 1)) ? '0 : RING_AW'(idx_r + 1'b1);
      last_cnt = RING_AW'(RING_DEPTH - 1);
      clk_val  = sum_r;
      clk_upd  = (idx_r == '0) || (idx_r == RING_AW'(RING_HALF));
    end else begin
      idx_new  = {{(RING_AW-1){1'b0}}, ~idx_r[0]};
      last_cnt = RING_AW'(1);
      clk_val  = sum_r >> 1;
      clk_upd  = 1'b1;
    end
    clk_sat = (clk_val[SUM_W-1:20] != '0);

    sm_diff   = {1'b0, tempo_r} - {1'b0, smooth_r};
    m_up      = {1'b0, m_r} + 45'd65535;
    hold_diff = (smooth_r >= held_r) ? smooth_r - held_r : held_r - smooth_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (ttt_func_t'(in_tuser))
            FN_TAP:   state_nxt = ST_TAP_MUL;
            FN_CLOCK: state_nxt = ST_CLK_CHK;
            FN_TICK:  state_nxt = ST_TICK_MUL;
            default:  state_nxt = ST_SET;
          endcase
        end
      end
      ST_TAP_MUL:   state_nxt = ST_TAP_DEC;
      ST_TAP_DEC:   state_nxt = (in_rng && !tol_fail && !sat_tap) ? ST_TAP_DIV : ST_DONE;
      ST_TAP_DIV:   state_nxt = div_done ? ST_DONE : ST_TAP_DIV;
      ST_CLK_CHK:   state_nxt = clk_ok ? ST_CLK_SUM : ST_DONE;
      ST_CLK_SUM:   state_nxt = (cnt_r == last_cnt) ? ST_CLK_DRAIN : ST_CLK_SUM;
      ST_CLK_DRAIN: state_nxt = ST_CLK_FIN;
      ST_CLK_FIN:   state_nxt = ST_DONE;
      ST_TICK_MUL:  state_nxt = ST_TICK_ADD;
      ST_TICK_ADD:  state_nxt = ST_TICK_HOLD;
      ST_TICK_HOLD: state_nxt = ST_DONE;
      ST_SET:       state_nxt = ST_DONE;
      ST_DONE:      state_nxt = (!out_v_r || out_tready) ? ST_IDLE : ST_DONE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    div_start = 1'b0;
    res_load  = 1'b0;
    case (state_r)
      ST_IDLE:    in_tready = 1'b1;
      ST_TAP_DEC: div_start = in_rng && !tol_fail && !sat_tap;
      ST_CLK_CHK: mem_we    = clk_ok;
      ST_CLK_SUM: mem_re    = 1'b1;
      ST_DONE:    res_load  = !out_v_r || out_tready;
      default:    ;
    endcase
  end

  always_comb begin
    div_req.start    = div_start;
    div_req.rem_init = ivx_r[DEN_W+6:7];
    div_req.low_init = {ivx_r[6:0], 21'd0};
    div_req.den      = den_r;
  end

  ttt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  // ring memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) ring_mem[idx_new] <= per_r;
    if (mem_re) begin
      rd_data_r <= ring_mem[cnt_r];
      rd_vld_r  <= ring_vld_r[cnt_r];
    end
  end

  // configuration and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r      <= '0;
      max_r      <= '1;
      tol_r      <= 16'd16384;
      ratio_r    <= 16'd4096;
      ppq_r      <= PPQ_LONG;
      state_r    <= ST_IDLE;
      out_v_r    <= 1'b0;
      ring_vld_r <= '0;
      rd_v_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (ttt_reg_t'(cfg_index))
          REG_MIN_TAP: min_r   <= cfg_wdata;
          REG_MAX_TAP: max_r   <= cfg_wdata;
          REG_TOL:     tol_r   <= cfg_wdata[15:0];
          REG_RATIO:   ratio_r <= cfg_wdata[15:0];
          REG_PPQ:     ppq_r   <= cfg_wdata[4:0];
          default:     ;
        endcase
      end
      state_r <= state_nxt;
      rd_v_r  <= mem_re;
      if (mem_we) ring_vld_r[idx_new] <= 1'b1;
      if (res_load)        out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_tap_r <= '0;
      last_int_r <= '0;
      first_r    <= 1'b0;
      tempo_r    <= TEMPO_RESET;
      smooth_r   <= '0;
      held_r     <= '0;
      idx_r      <= '0;
    end else begin
      case (state_r)
        ST_TAP_MUL: last_tap_r <= time_r;
        ST_TAP_DEC: begin
          if (in_rng) begin
            if (tol_fail) begin
              first_r <= 1'b1;
            end else begin
              first_r    <= 1'b0;
              last_int_r <= iv_r;
              if (sat_tap) tempo_r <= TEMPO_MAX;
            end
          end else if (iv_r > max_r) begin
            first_r <= 1'b1;
          end
        end
        ST_TAP_DIV: if (div_done) tempo_r <= div_quot;
        ST_CLK_CHK: if (clk_ok) idx_r <= idx_new;
        ST_CLK_FIN: begin
          if (clk_upd) tempo_r <= clk_sat ? TEMPO_MAX : {clk_val[19:0], 8'd0};
        end
        ST_TICK_ADD: begin
          if (neg_r) smooth_r <= smooth_r - m_up[TEMPO_W+15:16];
          else       smooth_r <= smooth_r + m_r[TEMPO_W+15:16];
        end
        ST_TICK_HOLD: if (hold_diff > HOLD_BAND) held_r <= smooth_r;
        ST_SET: tempo_r <= tval_r;
        default: ;
      endcase
    end
  end

  // item latch and datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      time_r <= in_tdata[31:0];
      per_r  <= in_tdata[51:32];
      tval_r <= in_tdata[79:52];
      upd_r  <= 1'b0;
    end
    case (state_r)
      ST_TAP_MUL: begin
        iv_r  <= iv;
        ivx_r <= {2'b00, iv} + {1'b0, iv, 1'b0};
        rhs_r <= tol_r * last_int_r;
        den_r <= DEN_W'(DEN_MUL) * DEN_W'(ratio_r);
      end
      ST_TAP_DEC:  upd_r <= in_rng && !tol_fail;
      ST_CLK_CHK:  sum_r <= '0;
      ST_CLK_FIN:  upd_r <= clk_upd;
      ST_TICK_MUL: begin
        neg_r <= sm_diff[TEMPO_W];
        m_r   <= (sm_diff[TEMPO_W] ? TEMPO_W'(-sm_diff) : sm_diff[TEMPO_W-1:0])
                 * (lng ? COEF_FAST : COEF_SLOW);
      end
      ST_SET:      upd_r <= 1'b1;
      default:     ;
    endcase
    if (state_r == ST_CLK_CHK)       cnt_r <= '0;
    else if (state_r == ST_CLK_SUM)  cnt_r <= cnt_r + 1'b1;
    if (rd_v_r && rd_vld_r) sum_r <= sum_r + SUM_W'(rd_data_r);
    if (res_load) begin
      out_upd_r  <= upd_r;
      out_data_r <= {last_int_r, held_r, tempo_r};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_upd_r;

endmodule

>>> rtl/core/ttt_checker.sv
//------------------------------------------------------------------------------
// ttt_checker
// Port-level checks of the tempo tracker, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata
);

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while previous one still in work");

  // a new result only comes out of a busy unit
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result dropped or changed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind tap_and_clock_tempo_tracker_unit ttt_checker u_ttt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> verif/testbench.sv
//------------------------------------------------------------------------------
// testbench
// Self-checking bench for the tap and clock tempo tracker: directed items per
// function, a long receiver hold-off, then random tap runs, clock streams, ticks
// and loads under bursty input and stalling output, checked against an in-bench
// tempo predictor.
`timescale 1ns / 1ps

module testbench;
  import ttt_pkg::*;

  // expected result of one item
  typedef struct packed {
    logic               upd;
    logic [TEMPO_W-1:0] tempo;
    logic [TEMPO_W-1:0] held;
    logic [31:0]        interval;
  } tempo_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;   // time_us[31:0], clock_period[51:32], tempo_value[79:52]
  logic [1:0]  in_tuser;   // func[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;  // tempo_now[27:0], delay_length[55:28], last_interval_us[87:56]
  logic [0:0]  out_tuser;  // tempo_updated[0]

  tap_and_clock_tempo_tracker_unit u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of the configuration
  logic [31:0] p_min_us, p_max_us;
  logic [15:0] p_tol, p_ratio;
  logic [4:0]  p_ppq;
  // predictor copy of the state
  logic [31:0]        p_last_time, p_last_iv;
  logic               p_first;
  logic [TEMPO_W-1:0] p_tempo, p_smooth, p_held;
  logic [19:0]        p_ring [RING_DEPTH];
  int unsigned        p_ring_idx;

  tempo_result_t expected_q[$];
  int          errors = 0;
  bit          hold_off = 1'b0;   // long receiver hold-off, its own process
  bit          stall_on = 1'b1;   // random receiver stalls on/off
  int unsigned idle_cycles = 0;

  function automatic logic [TEMPO_W-1:0] clamp_tempo(logic [63:0] v);
    return (v > {36'd0, TEMPO_MAX}) ? TEMPO_MAX : v[TEMPO_W-1:0];
  endfunction

  function automatic logic apply_tap(logic [31:0] t);
    logic [31:0] iv;
    iv = t - p_last_time;
    p_last_time = t;
    if (p_min_us <= iv && iv <= p_max_us) begin
      if (!p_first && ({18'd0, iv, 14'd0} >= 64'(p_tol) * 64'(p_last_iv))) begin
        p_first = 1'b1;
        return 1'b0;
      end
      p_first = 1'b0;
      // zero ratio saturates
      if (p_ratio == 0) p_tempo = TEMPO_MAX;
      else p_tempo = clamp_tempo((64'(iv) * 64'd6291456) / (64'd125 * 64'(p_ratio)));
      p_last_iv = iv;
      return 1'b1;
    end
    if (iv > p_max_us) p_first = 1'b1;
    return 1'b0;
  endfunction

  function automatic logic apply_clock(logic [19:0] per);
    int unsigned len, sum, val;
    bit long_mode;
    if (p_ppq == 0) return 1'b0;
    if (per < 960 / p_ppq || per > 288000 / p_ppq) return 1'b0;
    long_mode = (p_ppq == PPQ_LONG);
    len = long_mode ? RING_DEPTH : 2;
    p_ring_idx = (p_ring_idx + 1) % len;
    p_ring[p_ring_idx] = per;
    sum = 0;
    for (int i = 0; i < len; i++) sum += p_ring[i];
    val = long_mode ? sum : sum / 2;
    if (!long_mode || p_ring_idx % RING_HALF == 0) begin
      p_tempo = clamp_tempo(64'(val) << 8);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void apply_tick();
    logic [63:0] m;
    logic [TEMPO_W-1:0] diff;
    logic [15:0] c;
    c = (p_ppq == PPQ_LONG) ? COEF_FAST : COEF_SLOW;
    if (p_tempo >= p_smooth) begin
      m = 64'(p_tempo - p_smooth) * 64'(c);
      p_smooth = p_smooth + TEMPO_W'(m >> 16);
    end else begin
      m = 64'(p_smooth - p_tempo) * 64'(c);
      p_smooth = p_smooth - TEMPO_W'((m + 64'd65535) >> 16);
    end
    diff = (p_smooth >= p_held) ? p_smooth - p_held : p_held - p_smooth;
    if (diff > HOLD_BAND) p_held = p_smooth;
  endfunction

  function automatic tempo_result_t predict_tempo(ttt_func_t fn, logic [79:0] d);
    tempo_result_t r;
    r.upd = 1'b0;
    case (fn)
      FN_TAP:   r.upd = apply_tap(d[31:0]);
      FN_CLOCK: r.upd = apply_clock(d[51:32]);
      FN_TICK:  apply_tick();
      default: begin
        p_tempo = d[79:52];
        r.upd = 1'b1;
      end
    endcase
    r.tempo = p_tempo;
    r.held = p_held;
    r.interval = p_last_iv;
    return r;
  endfunction

  // accepted item -> expectation; out checks below
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      expected_q.push_back(predict_tempo(ttt_func_t'(in_tuser), in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h/%h", $time, out_tuser, out_tdata);
        errors++;
      end else begin
        tempo_result_t e;
        e = expected_q.pop_front();
        if (out_tuser[0] !== e.upd) begin
          $display("%0t: tempo_updated exp %0d got %0d", $time, e.upd, out_tuser[0]);
          errors++;
        end
        if (out_tdata[27:0] !== e.tempo) begin
          $display("%0t: tempo_now exp %0d got %0d", $time, e.tempo, out_tdata[27:0]);
          errors++;
        end
        if (out_tdata[55:28] !== e.held) begin
          $display("%0t: delay_length exp %0d got %0d", $time, e.held, out_tdata[55:28]);
          errors++;
        end
        if (out_tdata[87:56] !== e.interval) begin
          $display("%0t: last_interval exp %0d got %0d", $time, e.interval,
                   out_tdata[87:56]);
          errors++;
        end
      end
    end
  end

  // receiver: own stall pattern, plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_off) out_tready <= 1'b0;
    else if (!stall_on) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // watchdog: cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 4000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  int burst_left = 0;

  // send one item; sender idles in bursts with random gaps
  task automatic send_item(ttt_func_t fn, logic [31:0] t, logic [19:0] per,
                           logic [27:0] tv);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {tv, per, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // write one register while idle, mirror it in the predictor
  task automatic write_reg(ttt_reg_t idx, logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MIN_TAP: p_min_us = v;
      REG_MAX_TAP: p_max_us = v;
      REG_TOL:     p_tol = v[15:0];
      REG_RATIO:   p_ratio = v[15:0];
      default:     p_ppq = v[4:0];
    endcase
    @(posedge clk);
  endtask

  logic [31:0] tap_time = 0;

  task automatic tap_after(logic [31:0] dt);
    tap_time = tap_time + dt;
    send_item(FN_TAP, tap_time, 20'($urandom), 28'($urandom));
  endtask

  task automatic test_directed();
    tap_after(1000);            // first interval vs zero last: sets flag
    tap_after(500000);          // flagged: accepted
    tap_after(400000);          // within tolerance
    tap_after(450000);          // too slow relative to last: flag
    tap_after(32'hFFFF_FFFF);   // max interval, wraps
    tap_after(0);               // zero interval
    send_item(FN_CLOCK, $urandom, 20'd0, 28'($urandom));        // too short
    send_item(FN_CLOCK, $urandom, 20'hFFFFF, 28'($urandom));    // too long
    send_item(FN_CLOCK, $urandom, 20'd40, 28'($urandom));       // low limit
    send_item(FN_CLOCK, $urandom, 20'd12000, 28'($urandom));    // high limit
    send_item(FN_SET, $urandom, 20'($urandom), 28'hFFF_FFFF);
    send_item(FN_TICK, $urandom, 20'($urandom), 28'($urandom));
    send_item(FN_SET, $urandom, 20'($urandom), 28'd0);
    send_item(FN_TICK, $urandom, 20'($urandom), 28'($urandom));
    send_item(FN_SET, $urandom, 20'($urandom), 28'd0);          // same value still updates
    send_item(FN_TICK, $urandom, 20'($urandom), 28'($urandom));
    drain();
    // zero ratio and crossed limits
    write_reg(REG_RATIO, 32'd0);
    write_reg(REG_MIN_TAP, 32'd5000);
    write_reg(REG_MAX_TAP, 32'd100);
    tap_after(200);             // above max: flag
    tap_after(3000);            // between: rejected
    drain();
    write_reg(REG_MAX_TAP, 32'hFFFF_FFFF);
    tap_after(6000);            // flagged, zero ratio: saturate
    drain();
    write_reg(REG_PPQ, 32'd0);  // zero pulses: clocks ignored
    send_item(FN_CLOCK, $urandom, 20'd500, 28'($urandom));
    drain();
  endtask

  // one random phase of about n items
  task automatic random_phase(int n);
    int k;
    k = 0;
    while (k < n) begin
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        // well-formed tap run with occasional off-beat tap
        int base, len;
        base = $urandom_range(1000, 1500000);
        len = $urandom_range(2, 8);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(0, 5) == 0) tap_after($urandom);
          else tap_after(base + $urandom_range(0, base / 8));
        end
        k += len;
      end else if (kind < 7) begin
        int len;
        int unsigned q;
        len = $urandom_range(2, 26);
        q = (p_ppq == 0) ? 1 : p_ppq;
        for (int j = 0; j < len; j++)
          send_item(FN_CLOCK, $urandom,
                    ($urandom_range(0, 7) == 0) ? 20'($urandom)
                                                : 20'($urandom_range(960 / q, 288000 / q)),
                    28'($urandom));
        k += len;
      end else if (kind < 9) begin
        send_item(FN_TICK, $urandom, 20'($urandom), 28'($urandom));
        k++;
      end else begin
        send_item(FN_SET, $urandom, 20'($urandom), ($urandom_range(0, 1) == 0) ?
                  28'($urandom) : 28'($urandom_range(0, 1 << 20)));
        k++;
      end
    end
    drain();
  endtask

  task automatic test_random();
    write_reg(REG_MIN_TAP, 32'd0);
    write_reg(REG_MAX_TAP, 32'hFFFF_FFFF);
    write_reg(REG_TOL, 32'd16384);
    write_reg(REG_RATIO, 32'd4096);
    write_reg(REG_PPQ, 32'd24);
    random_phase(120);
    write_reg(REG_TOL, 32'd65535);
    write_reg(REG_RATIO, 32'd65535);
    write_reg(REG_PPQ, 32'd4);   // mode change keeps stale ring entries
    random_phase(100);
    write_reg(REG_MIN_TAP, 32'd2000);
    write_reg(REG_MAX_TAP, 32'd900000);
    write_reg(REG_TOL, 32'd24576);
    write_reg(REG_RATIO, 32'd1);
    write_reg(REG_PPQ, 32'd1);
    stall_on = 1'b0;
    random_phase(80);
    stall_on = 1'b1;
    write_reg(REG_TOL, 32'd0);
    write_reg(REG_RATIO, 32'($urandom_range(1, 65535)));
    write_reg(REG_PPQ, 32'd24);
    random_phase(100);
  endtask

  // receiver holds off long while sender keeps offering
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int j = 0; j < 10; j++)
        send_item(FN_SET, $urandom, 20'($urandom), 28'($urandom));
    join
    drain();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    p_min_us = '0;
    p_max_us = 32'hFFFF_FFFF;
    p_tol = 16'd16384;
    p_ratio = 16'd4096;
    p_ppq = PPQ_LONG;
    p_last_time = '0;
    p_last_iv = '0;
    p_first = 1'b0;
    p_tempo = TEMPO_RESET;
    p_smooth = '0;
    p_held = '0;
    p_ring_idx = 0;
    foreach (p_ring[i]) p_ring[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
